FILE: rtl/scf_pkg.sv
// Shared widths, constants and multiply-accumulate control types.
`default_nettype none
package scf_pkg;
   localparam int COORD_W    = 24;
   localparam int COORD_FRAC = 8;
   localparam int FRAC_W     = 16;
   localparam int MUL_W      = 27;
   localparam int CHUNK_W    = 26;
   localparam int ACC_W      = 104;
   localparam int WIDE_W     = COORD_W + 4;
   localparam int REQ_DATA_W = 184;
   localparam int RSP_DATA_W = 72;

   localparam logic [1:0] SH_0 = 2'd0;
   localparam logic [1:0] SH_1 = 2'd1;
   localparam logic [1:0] SH_2 = 2'd2;

   typedef enum logic [1:0] {
      KIND_SEG  = 2'd0,
      KIND_CAND = 2'd1,
      KIND_FIN  = 2'd2,
      KIND_RSVD = 2'd3
   } kind_type;

   typedef struct packed {
      logic       valid;
      logic       clr;
      logic       neg;
      logic [1:0] sh;
   } mac_ctl_type;

   typedef struct packed {
      mac_ctl_type        ctl;
      logic signed [MUL_W-1:0] a;
      logic signed [MUL_W-1:0] b;
   } mac_op_type;
endpackage
`default_nettype wire

FILE: rtl/swept_circle_first_hit.sv
// Top level: request decode, sequencer, sqrt/divide steps and result register.
//
//   channel   dir   handshake              payload
//   req       in    req_tvalid/req_tready  tuser kind, tdata segment/target
//   rsp       out   rsp_tvalid/rsp_tready  tdata hit, fraction, end point
//
// Candidate: up to four multiply passes on the shared multiplier, then the
// 50-step square root and 17-step divide on the shared subtractor.
// Finish request: holds until the result register is free.
// req_tready is high only in the idle state. Reset is synchronous.
`default_nettype none
module swept_circle_first_hit import scf_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [23:0] start_x, [47:24] start_y, [71:48] vel_x, [95:72] vel_y,
   // [111:96] time_step, [134:112] area_radius, [158:135] target_x,
   // [182:159] target_y, [183] eligible
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] kind
   input  wire logic [1:0]            req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [0] hit, [17:1] travel_fraction, [41:18] end_x, [65:42] end_y
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SEG  = 4'd1;
   localparam logic [3:0] S_CC   = 4'd2;
   localparam logic [3:0] S_CL   = 4'd3;
   localparam logic [3:0] S_CB   = 4'd4;
   localparam logic [3:0] S_CD   = 4'd5;
   localparam logic [3:0] S_SQRT = 4'd6;
   localparam logic [3:0] S_NCHK = 4'd7;
   localparam logic [3:0] S_DIV  = 4'd8;
   localparam logic [3:0] S_FIN  = 4'd9;
   localparam logic [3:0] S_EMIT = 4'd10;

   localparam int SQRT_STEPS = 50;
   localparam int DIV_STEPS  = FRAC_W + 1;
   localparam int DISC_W     = 2 * SQRT_STEPS;
   localparam int REM_W      = 52;
   localparam int SUB_W      = 54;
   localparam int C_W        = 51;
   localparam int LEN_W      = 48;
   localparam int NB_W       = 49;
   localparam int BEST_W     = FRAC_W + 2;
   localparam int TR_W       = FRAC_W + 1;
   localparam int RAD_W      = COORD_W - 1;

   localparam logic [BEST_W-1:0] ONE_FRAC = BEST_W'(1) << FRAC_W;
   localparam logic [BEST_W-1:0] NO_HIT   = BEST_W'(2) << FRAC_W;
   localparam logic [RAD_W-1:0]  RAD_MIN  = RAD_W'(1) << (COORD_FRAC - 1);
   localparam logic signed [WIDE_W-1:0] COORD_MAX =
      (WIDE_W'(1) <<< (COORD_W - 1)) - WIDE_W'(1);
   localparam logic signed [WIDE_W-1:0] COORD_MIN = -(WIDE_W'(1) <<< (COORD_W - 1));
   localparam logic signed [ACC_W-1:0]  ROUND_HALF = ACC_W'(1) <<< (FRAC_W - 1);

   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [WIDE_W-1:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > COORD_MAX) begin
         r = COORD_MAX[COORD_W-1:0];
      end else if (v < COORD_MIN) begin
         r = COORD_MIN[COORD_W-1:0];
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [WIDE_W-1:0] round_frac(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] t;
      t = (v + ROUND_HALF) >>> FRAC_W;
      return t[WIDE_W-1:0];
   endfunction

   logic signed [COORD_W-1:0] in_start_x, in_start_y, in_vel_x, in_vel_y;
   logic signed [COORD_W-1:0] in_target_x, in_target_y;
   logic [FRAC_W-1:0]         in_time_step;
   logic [RAD_W-1:0]          in_radius;
   logic                      in_eligible;

   assign in_start_x   = req_tdata[23:0];
   assign in_start_y   = req_tdata[47:24];
   assign in_vel_x     = req_tdata[71:48];
   assign in_vel_y     = req_tdata[95:72];
   assign in_time_step = req_tdata[111:96];
   assign in_radius    = req_tdata[134:112];
   assign in_target_x  = req_tdata[158:135];
   assign in_target_y  = req_tdata[182:159];
   assign in_eligible  = req_tdata[183];

   logic [3:0]                state_ff, state_in;
   logic [5:0]                step_ff, step_in;
   logic signed [COORD_W-1:0] start_x_ff, start_x_in, start_y_ff, start_y_in;
   logic signed [COORD_W-1:0] vel_x_ff, vel_x_in, vel_y_ff, vel_y_in;
   logic [FRAC_W-1:0]         ts_ff, ts_in;
   logic signed [COORD_W-1:0] disp_x_ff, disp_x_in, disp_y_ff, disp_y_in;
   logic [RAD_W-1:0]          radius_ff, radius_in;
   logic [BEST_W-1:0]         best_ff, best_in;
   logic                      inside_ff, inside_in;
   logic signed [COORD_W:0]   ox_ff, ox_in, oy_ff, oy_in;
   logic [C_W-1:0]            c_ff, c_in;
   logic [LEN_W-1:0]          len_ff, len_in;
   logic [NB_W-1:0]           nb_ff, nb_in;
   logic [DISC_W-1:0]         disc_ff, disc_in;
   logic [REM_W-1:0]          rem_ff, rem_in;
   logic [SQRT_STEPS-1:0]     root_ff, root_in;
   logic [TR_W-1:0]           q_ff, q_in, q_new;
   logic [TR_W-1:0]           tr_ff, tr_in;
   logic                      hit_ff, hit_in;
   logic signed [COORD_W-1:0] ex_ff, ex_in, ey_ff, ey_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;

   logic [BEST_W-1:0]         imp;
   logic [SUB_W-1:0]          sub_a, sub_b;
   logic [SUB_W:0]            diff;
   logic                      ge;
   logic [NB_W-1:0]           n_val;
   logic                      acc_le0;
   mac_op_type                op;
   logic signed [ACC_W-1:0]   acc;
   logic                      req_fire;

   scf_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .op_in   (op),
      .acc_out (acc)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign acc_le0    = acc[ACC_W-1] || (acc == '0);
   assign imp        = inside_ff ? '0 : best_ff;

   // shared subtractor for root, remainder and divide steps
   always_comb begin
      case (state_ff)
         S_SQRT: begin
            sub_a = {rem_ff, disc_ff[DISC_W-1 -: 2]};
            sub_b = SUB_W'({root_ff, 2'b01});
         end
         S_NCHK: begin
            sub_a = SUB_W'(nb_ff);
            sub_b = SUB_W'(root_ff);
         end
         S_DIV: begin
            sub_a = SUB_W'(rem_ff);
            sub_b = SUB_W'(len_ff);
         end
         default: begin
            sub_a = '0;
            sub_b = '0;
         end
      endcase
      diff  = {1'b0, sub_a} - {1'b0, sub_b};
      ge    = ~diff[SUB_W];
      n_val = diff[NB_W-1:0];
      q_new = {q_ff[TR_W-2:0], ge};
   end

   // multiplier program
   always_comb begin
      op = '0;
      case (state_ff)
         S_SEG: begin
            op.ctl.valid = (step_ff < 6'd2);
            op.ctl.clr   = 1'b1;
            op.a = (step_ff == 6'd0) ? MUL_W'(vel_x_ff) : MUL_W'(vel_y_ff);
            op.b = MUL_W'(ts_ff);
         end
         S_FIN: begin
            op.ctl.valid = (step_ff < 6'd2);
            op.ctl.clr   = 1'b1;
            op.a = (step_ff == 6'd0) ? MUL_W'(disp_x_ff) : MUL_W'(disp_y_ff);
            op.b = MUL_W'(tr_ff);
         end
         S_CC: begin
            op.ctl.valid = (step_ff < 6'd3);
            op.ctl.clr   = (step_ff == 6'd0);
            op.ctl.neg   = (step_ff == 6'd2);
            case (step_ff)
               6'd0: begin
                  op.a = MUL_W'(ox_ff);
                  op.b = MUL_W'(ox_ff);
               end
               6'd1: begin
                  op.a = MUL_W'(oy_ff);
                  op.b = MUL_W'(oy_ff);
               end
               default: begin
                  op.a = MUL_W'(radius_ff);
                  op.b = MUL_W'(radius_ff);
               end
            endcase
         end
         S_CL: begin
            op.ctl.valid = (step_ff < 6'd2);
            op.ctl.clr   = (step_ff == 6'd0);
            op.a = (step_ff == 6'd0) ? MUL_W'(disp_x_ff) : MUL_W'(disp_y_ff);
            op.b = op.a;
         end
         S_CB: begin
            op.ctl.valid = (step_ff < 6'd2);
            op.ctl.clr   = (step_ff == 6'd0);
            op.a = (step_ff == 6'd0) ? MUL_W'(ox_ff) : MUL_W'(oy_ff);
            op.b = (step_ff == 6'd0) ? MUL_W'(disp_x_ff) : MUL_W'(disp_y_ff);
         end
         S_CD: begin
            op.ctl.valid = (step_ff < 6'd8);
            op.ctl.clr   = (step_ff == 6'd0);
            op.ctl.neg   = (step_ff >= 6'd4);
            case (step_ff)
               6'd0: begin
                  op.a = MUL_W'(nb_ff[CHUNK_W-1:0]);
                  op.b = MUL_W'(nb_ff[CHUNK_W-1:0]);
                  op.ctl.sh = SH_0;
               end
               6'd1, 6'd2: begin
                  op.a = MUL_W'(nb_ff[CHUNK_W-1:0]);
                  op.b = MUL_W'(nb_ff[NB_W-1:CHUNK_W]);
                  op.ctl.sh = SH_1;
               end
               6'd3: begin
                  op.a = MUL_W'(nb_ff[NB_W-1:CHUNK_W]);
                  op.b = MUL_W'(nb_ff[NB_W-1:CHUNK_W]);
                  op.ctl.sh = SH_2;
               end
               6'd4: begin
                  op.a = MUL_W'(len_ff[CHUNK_W-1:0]);
                  op.b = MUL_W'(c_ff[CHUNK_W-1:0]);
                  op.ctl.sh = SH_0;
               end
               6'd5: begin
                  op.a = MUL_W'(len_ff[CHUNK_W-1:0]);
                  op.b = MUL_W'(c_ff[C_W-1:CHUNK_W]);
                  op.ctl.sh = SH_1;
               end
               6'd6: begin
                  op.a = MUL_W'(len_ff[LEN_W-1:CHUNK_W]);
                  op.b = MUL_W'(c_ff[CHUNK_W-1:0]);
                  op.ctl.sh = SH_1;
               end
               default: begin
                  op.a = MUL_W'(len_ff[LEN_W-1:CHUNK_W]);
                  op.b = MUL_W'(c_ff[C_W-1:CHUNK_W]);
                  op.ctl.sh = SH_2;
               end
            endcase
         end
         default: op = '0;
      endcase
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff + 6'd1;
      start_x_in = start_x_ff;
      start_y_in = start_y_ff;
      vel_x_in   = vel_x_ff;
      vel_y_in   = vel_y_ff;
      ts_in      = ts_ff;
      disp_x_in  = disp_x_ff;
      disp_y_in  = disp_y_ff;
      radius_in  = radius_ff;
      best_in    = best_ff;
      inside_in  = inside_ff;
      ox_in      = ox_ff;
      oy_in      = oy_ff;
      c_in       = c_ff;
      len_in     = len_ff;
      nb_in      = nb_ff;
      disc_in    = disc_ff;
      rem_in     = rem_ff;
      root_in    = root_ff;
      q_in       = q_ff;
      tr_in      = tr_ff;
      hit_in     = hit_ff;
      ex_in      = ex_ff;
      ey_in      = ey_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         S_IDLE: begin
            step_in = '0;
            if (req_fire) begin
               case (req_tuser)
                  KIND_SEG: begin
                     start_x_in = in_start_x;
                     start_y_in = in_start_y;
                     vel_x_in   = in_vel_x;
                     vel_y_in   = in_vel_y;
                     ts_in      = in_time_step;
                     radius_in  = (in_radius < RAD_MIN) ? RAD_MIN : in_radius;
                     best_in    = NO_HIT;
                     inside_in  = 1'b0;
                     state_in   = S_SEG;
                  end
                  KIND_CAND: begin
                     ox_in = (COORD_W+1)'(start_x_ff) - (COORD_W+1)'(in_target_x);
                     oy_in = (COORD_W+1)'(start_y_ff) - (COORD_W+1)'(in_target_y);
                     if (in_eligible && !inside_ff) begin
                        state_in = S_CC;
                     end
                  end
                  KIND_FIN: begin
                     tr_in    = (imp < ONE_FRAC) ? imp[TR_W-1:0] : ONE_FRAC[TR_W-1:0];
                     hit_in   = (imp <= ONE_FRAC);
                     state_in = S_FIN;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_SEG: begin
            if (step_ff == 6'd2) begin
               disp_x_in = sat_coord(round_frac(acc));
            end
            if (step_ff == 6'd3) begin
               disp_y_in = sat_coord(round_frac(acc));
               state_in  = S_IDLE;
            end
         end
         S_CC: begin
            if (step_ff == 6'd4) begin
               step_in = '0;
               c_in    = acc[C_W-1:0];
               if (acc_le0) begin
                  inside_in = 1'b1;
                  best_in   = '0;
                  state_in  = S_IDLE;
               end else begin
                  state_in  = S_CL;
               end
            end
         end
         S_CL: begin
            if (step_ff == 6'd3) begin
               step_in  = '0;
               len_in   = acc[LEN_W-1:0];
               state_in = (acc == '0) ? S_IDLE : S_CB;
            end
         end
         S_CB: begin
            if (step_ff == 6'd3) begin
               step_in  = '0;
               nb_in    = NB_W'(-acc);
               state_in = acc[ACC_W-1] ? S_CD : S_IDLE;
            end
         end
         S_CD: begin
            if (step_ff == 6'd9) begin
               step_in  = '0;
               disc_in  = acc[DISC_W-1:0];
               rem_in   = '0;
               root_in  = '0;
               state_in = acc[ACC_W-1] ? S_IDLE : S_SQRT;
            end
         end
         S_SQRT: begin
            rem_in  = ge ? diff[REM_W-1:0] : sub_a[REM_W-1:0];
            root_in = {root_ff[SQRT_STEPS-2:0], ge};
            disc_in = disc_ff << 2;
            if (step_ff == 6'(SQRT_STEPS - 1)) begin
               step_in  = '0;
               state_in = S_NCHK;
            end
         end
         S_NCHK: begin
            step_in  = '0;
            rem_in   = REM_W'(n_val);
            q_in     = '0;
            state_in = (n_val > NB_W'(len_ff)) ? S_IDLE : S_DIV;
         end
         S_DIV: begin
            q_in   = q_new;
            rem_in = ge ? REM_W'(diff[SUB_W-1:0] << 1) : REM_W'(sub_a << 1);
            if (step_ff == 6'(DIV_STEPS - 1)) begin
               step_in = '0;
               if (BEST_W'(q_new) < best_ff) begin
                  best_in = BEST_W'(q_new);
               end
               state_in = S_IDLE;
            end
         end
         S_FIN: begin
            if (step_ff == 6'd2) begin
               ex_in = sat_coord(WIDE_W'(start_x_ff) + round_frac(acc));
            end
            if (step_ff == 6'd3) begin
               ey_in    = sat_coord(WIDE_W'(start_y_ff) + round_frac(acc));
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            step_in = '0;
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({ey_ff, ex_ff, tr_ff, hit_ff});
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         start_x_ff   <= '0;
         start_y_ff   <= '0;
         disp_x_ff    <= '0;
         disp_y_ff    <= '0;
         radius_ff    <= '0;
         best_ff      <= NO_HIT;
         inside_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         start_x_ff   <= start_x_in;
         start_y_ff   <= start_y_in;
         disp_x_ff    <= disp_x_in;
         disp_y_ff    <= disp_y_in;
         radius_ff    <= radius_in;
         best_ff      <= best_in;
         inside_ff    <= inside_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      vel_x_ff    <= vel_x_in;
      vel_y_ff    <= vel_y_in;
      ts_ff       <= ts_in;
      ox_ff       <= ox_in;
      oy_ff       <= oy_in;
      c_ff        <= c_in;
      len_ff      <= len_in;
      nb_ff       <= nb_in;
      disc_ff     <= disc_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      q_ff        <= q_in;
      tr_ff       <= tr_in;
      hit_ff      <= hit_in;
      ex_ff       <= ex_in;
      ey_ff       <= ey_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
endmodule
`default_nettype wire

FILE: rtl/scf_mac.sv
// Shared registered multiplier with shifted add/subtract accumulator.
`default_nettype none
module scf_mac import scf_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire mac_op_type              op_in,
   output logic signed [ACC_W-1:0]      acc_out
);
   logic signed [2*MUL_W-1:0] prod_ff, prod_in;
   mac_ctl_type               ctl_ff, ctl_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in, term, shifted, base;

   always_comb begin
      prod_in = op_in.a * op_in.b;
      ctl_in  = op_in.ctl;
      term    = ACC_W'(prod_ff);
      case (ctl_ff.sh)
         SH_0: shifted = term;
         SH_1: shifted = term <<< CHUNK_W;
         SH_2: shifted = term <<< (2 * CHUNK_W);
         default: shifted = term;
      endcase
      base = ctl_ff.clr ? '0 : acc_ff;
      if (ctl_ff.valid) begin
         acc_in = ctl_ff.neg ? base - shifted : base + shifted;
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc_out = acc_ff;
endmodule
`default_nettype wire

FILE: tb/swept_circle_first_hit_tb.sv
// Testbench for the swept-circle first-hit block: directed table, random segment runs, self-checked.
`default_nettype none
module swept_circle_first_hit_tb import scf_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint ONE_FRAC = 64'd1 << FRAC_W;
   localparam longint NO_HIT   = 64'd2 << FRAC_W;
   localparam longint C_MAX    = (64'sd1 <<< (COORD_W - 1)) - 1;
   localparam longint C_MIN    = -(64'sd1 <<< (COORD_W - 1));

   typedef struct packed {
      logic        eligible;
      logic [23:0] ty;
      logic [23:0] tx;
      logic [22:0] radius;
      logic [15:0] tstep;
      logic [23:0] vy;
      logic [23:0] vx;
      logic [23:0] sy;
      logic [23:0] sx;
   } req_fields_type;

   typedef struct packed {
      logic [5:0]  pad;
      logic [23:0] ey;
      logic [23:0] ex;
      logic [16:0] frac;
      logic        hit;
   } rsp_fields_type;

   typedef struct {
      kind_type       kind;
      req_fields_type f;
      bit             fixed;
      rsp_fields_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   swept_circle_first_hit u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   longint m_sx, m_sy, m_dx, m_dy, m_rad;
   longint unsigned m_best;
   bit m_inside;
   rsp_fields_type hit_queue[$];
   int errors = 0;
   bit quiet = 1'b0;
   int stall = 0;

   function automatic longint sat_c(longint v);
      if (v > C_MAX) return C_MAX;
      if (v < C_MIN) return C_MIN;
      return v;
   endfunction

   function automatic longint rnd_shift(longint v);
      longint t;
      t = v + (64'sd1 <<< (FRAC_W - 1));
      return t >>> FRAC_W;
   endfunction

   function automatic longint unsigned isqrt(logic [127:0] d);
      logic [127:0] s, c;
      s = '0;
      for (int b = 63; b >= 0; b--) begin
         c = s | (128'd1 << b);
         if (c * c <= d) s = c;
      end
      return s[63:0];
   endfunction

   function automatic void sweep_candidate(longint tx, longint ty);
      longint ox, oy, c, len, b;
      longint unsigned nb, s, n, q, rem, len_u;
      logic [127:0] b2, lc;
      ox = m_sx - tx;
      oy = m_sy - ty;
      c = ox * ox + oy * oy - m_rad * m_rad;
      len = m_dx * m_dx + m_dy * m_dy;
      if (c <= 0) begin
         m_inside = 1'b1;
         m_best = 0;
         return;
      end
      if (len <= 0) return;
      b = ox * m_dx + oy * m_dy;
      if (b >= 0) return;
      nb = -b;
      len_u = len;
      b2 = 128'(nb) * 128'(nb);
      lc = 128'(len_u) * 128'(c);
      if (b2 < lc) return;
      s = isqrt(b2 - lc);
      n = nb - s;
      if (n > len_u) return;
      q = 0;
      rem = n;
      if (rem >= len_u) begin
         q = 1;
         rem -= len_u;
      end
      for (int i = 0; i < FRAC_W; i++) begin
         rem <<= 1;
         q <<= 1;
         if (rem >= len_u) begin
            rem -= len_u;
            q |= 1;
         end
      end
      if (q < m_best) m_best = q;
   endfunction

   function automatic void predict_hit(kind_type k, req_fields_type f);
      longint ts, imp, tr;
      rsp_fields_type r;
      case (k)
         KIND_SEG: begin
            ts = f.tstep;
            m_sx = longint'($signed(f.sx));
            m_sy = longint'($signed(f.sy));
            m_dx = sat_c(rnd_shift(longint'($signed(f.vx)) * ts));
            m_dy = sat_c(rnd_shift(longint'($signed(f.vy)) * ts));
            m_rad = (f.radius < 23'd128) ? 128 : longint'(f.radius);
            m_best = NO_HIT;
            m_inside = 1'b0;
         end
         KIND_CAND: begin
            if (f.eligible && !m_inside)
               sweep_candidate(longint'($signed(f.tx)), longint'($signed(f.ty)));
         end
         KIND_FIN: begin
            imp = m_inside ? 0 : longint'(m_best);
            tr = (imp < ONE_FRAC) ? imp : ONE_FRAC;
            r = '0;
            r.hit = (imp <= ONE_FRAC);
            r.frac = tr[16:0];
            r.ex = 24'(sat_c(m_sx + rnd_shift(m_dx * tr)));
            r.ey = 24'(sat_c(m_sy + rnd_shift(m_dy * tr)));
            hit_queue.insert(hit_queue.size(), r);
         end
         default: ;
      endcase
   endfunction

   task automatic send_req(kind_type k, req_fields_type f);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 15);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= k;
      req_tdata <= REQ_DATA_W'(f);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_hit(k, f);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         stall = 0;
         rsp_tready <= 1'b0;
      end else if (quiet) begin
         stall = 0;
         rsp_tready <= 1'b1;
      end else if (stall > 0) begin
         stall = stall - 1;
         rsp_tready <= (stall == 0);
      end else if ($urandom_range(0, 5) == 0) begin
         stall = $urandom_range(1, 15);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_fields_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_fields_type'(rsp_tdata);
         if (hit_queue.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = hit_queue.pop_front();
            if (got.hit !== want.hit) begin
               $display("%0t: hit exp %0d got %0d", $time, want.hit, got.hit);
               errors++;
            end
            if (got.frac !== want.frac) begin
               $display("%0t: fraction exp %0d got %0d", $time, want.frac, got.frac);
               errors++;
            end
            if (got.ex !== want.ex) begin
               $display("%0t: end_x exp %h got %h", $time, want.ex, got.ex);
               errors++;
            end
            if (got.ey !== want.ey) begin
               $display("%0t: end_y exp %h got %h", $time, want.ey, got.ey);
               errors++;
            end
         end
      end
   end

   function automatic req_fields_type seg_fields(logic [23:0] sx, logic [23:0] sy,
         logic [23:0] vx, logic [23:0] vy, logic [15:0] ts, logic [22:0] rad);
      req_fields_type f;
      f = '0;
      f.sx = sx; f.sy = sy; f.vx = vx; f.vy = vy; f.tstep = ts; f.radius = rad;
      return f;
   endfunction

   function automatic req_fields_type cand_fields(logic [23:0] tx, logic [23:0] ty,
         logic el);
      req_fields_type f;
      f = '0;
      f.tx = tx; f.ty = ty; f.eligible = el;
      return f;
   endfunction

   function automatic rsp_fields_type rsp_of(logic h, logic [16:0] fr, logic [23:0] ex,
         logic [23:0] ey);
      rsp_fields_type r;
      r = '0;
      r.hit = h; r.frac = fr; r.ex = ex; r.ey = ey;
      return r;
   endfunction

   function automatic logic [23:0] rnd_coord(int span);
      int v;
      v = $urandom_range(0, 2 * span) - span;
      return v[23:0];
   endfunction

   function automatic req_fields_type random_noise();
      logic [191:0] raw;
      req_fields_type f;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      f = raw[REQ_DATA_W-1:0];
      return f;
   endfunction

   stim_row_type plan[$];

   task automatic add_row(kind_type k, req_fields_type f, bit fx = 0,
         rsp_fields_type w = '0);
      stim_row_type r;
      r.kind = k; r.f = f; r.fixed = fx; r.want = w;
      plan.insert(plan.size(), r);
   endtask

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      int n_cand, span;
      logic [23:0] sx, sy;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      add_row(KIND_FIN, '0, 1, rsp_of(1'b0, 17'd65536, 24'd0, 24'd0));
      add_row(KIND_CAND, cand_fields(24'd0, 24'd0, 1'b1));
      add_row(KIND_FIN, '0, 1, rsp_of(1'b1, 17'd0, 24'd0, 24'd0));
      add_row(KIND_SEG, seg_fields(24'h7fffff, 24'h800000, 24'h7fffff, 24'h800000,
              16'hffff, 23'h7fffff));
      add_row(KIND_CAND, cand_fields(24'h800000, 24'h7fffff, 1'b1));
      add_row(KIND_FIN, '0);
      add_row(KIND_SEG, seg_fields(24'd0, 24'd0, 24'd2560, 24'd0, 16'hffff, 23'd0));
      add_row(KIND_CAND, cand_fields(24'd1280, 24'd0, 1'b0));
      add_row(KIND_FIN, '0);
      add_row(KIND_CAND, cand_fields(24'd1280, 24'd64, 1'b1));
      add_row(KIND_CAND, cand_fields(24'd640, 24'd0, 1'b1));
      add_row(KIND_CAND, cand_fields(-24'd2560, 24'd0, 1'b1));
      add_row(KIND_FIN, '0);
      add_row(KIND_FIN, '0);
      add_row(KIND_CAND, cand_fields(24'd10, 24'd0, 1'b1));
      add_row(KIND_CAND, cand_fields(24'd1000, 24'd0, 1'b1));
      add_row(KIND_FIN, '0);
      add_row(KIND_RSVD, random_noise());
      add_row(KIND_SEG, seg_fields(24'h800000, 24'h7fffff, 24'd0, 24'd0, 16'd0, 23'd64));
      add_row(KIND_CAND, cand_fields(24'h800000, 24'h7fffff, 1'b1));
      add_row(KIND_FIN, '0, 1, rsp_of(1'b1, 17'd0, 24'h800000, 24'h7fffff));
      add_row(KIND_SEG, seg_fields(24'd0, 24'd0, 24'd4096, 24'd0, 16'h8000, 23'd300));
      add_row(KIND_CAND, cand_fields(24'd0, 24'd3000, 1'b1));
      add_row(KIND_FIN, '0);

      foreach (plan[i]) begin
         send_req(plan[i].kind, plan[i].f);
         if (plan[i].fixed && plan[i].kind == KIND_FIN) begin
            void'(hit_queue.pop_back());
            hit_queue.insert(hit_queue.size(), plan[i].want);
         end
      end

      for (int items = 0; items < 450; ) begin
         if ($urandom_range(0, 9) == 0) begin
            send_req(kind_type'($urandom_range(0, 3)), random_noise());
            items++;
            continue;
         end
         if (items > 380) quiet = 1'b1;
         span = ($urandom_range(0, 7) == 0) ? 8388607 : 20000;
         sx = rnd_coord(span);
         sy = rnd_coord(span);
         send_req(KIND_SEG, seg_fields(sx, sy, rnd_coord(span), rnd_coord(span),
                  16'($urandom),
                  23'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2000))));
         n_cand = $urandom_range(0, 4);
         for (int c = 0; c < n_cand; c++)
            send_req(KIND_CAND, cand_fields(24'(sx + rnd_coord(span)),
                     24'(sy + rnd_coord(span)), ($urandom_range(0, 4) != 0)));
         send_req(KIND_FIN, random_noise());
         items += n_cand + 2;
      end
      req_tvalid <= 1'b0;
      quiet = 1'b1;

      while (hit_queue.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
